// ----- hw/rtl/c8ie_pkg.sv -----
// Shared types, codes and helpers of the CHIP-8 instruction execute block.
package c8ie_pkg;

  localparam int unsigned MemAw = 12;
  localparam int unsigned VRegAw = 4;

  localparam logic [11:0] DispBase = 12'h100;
  localparam logic [11:0] FontBase = 12'h800;

  localparam logic [15:0] OpHalt = 16'hF000;
  localparam logic [15:0] OpNop = 16'h0000;
  localparam logic [15:0] OpCls = 16'h00E0;
  localparam logic [15:0] OpRet = 16'h00EE;

  // item modes
  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeExec = 2'd1;
  localparam logic [1:0] ModeRead = 2'd2;

  // error codes
  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrRetEmpty = 2'd1;
  localparam logic [1:0] ErrCallFull = 2'd2;
  localparam logic [1:0] ErrBadOp = 2'd3;

  // opcode groups (top nibble)
  localparam logic [3:0] GrpSys = 4'h0;
  localparam logic [3:0] GrpJump = 4'h1;
  localparam logic [3:0] GrpCall = 4'h2;
  localparam logic [3:0] GrpSkipEqI = 4'h3;
  localparam logic [3:0] GrpSkipNeI = 4'h4;
  localparam logic [3:0] GrpSkipEqR = 4'h5;
  localparam logic [3:0] GrpLoadI = 4'h6;
  localparam logic [3:0] GrpAddI = 4'h7;
  localparam logic [3:0] GrpAlu = 4'h8;
  localparam logic [3:0] GrpSkipNeR = 4'h9;
  localparam logic [3:0] GrpSetIdx = 4'hA;
  localparam logic [3:0] GrpJumpV0 = 4'hB;
  localparam logic [3:0] GrpRand = 4'hC;
  localparam logic [3:0] GrpDraw = 4'hD;
  localparam logic [3:0] GrpKey = 4'hE;
  localparam logic [3:0] GrpMisc = 4'hF;

  // ALU functions (low nibble of 8XYN)
  localparam logic [3:0] AluMov = 4'h0;
  localparam logic [3:0] AluOr = 4'h1;
  localparam logic [3:0] AluAnd = 4'h2;
  localparam logic [3:0] AluXor = 4'h3;
  localparam logic [3:0] AluAdd = 4'h4;
  localparam logic [3:0] AluSub = 4'h5;
  localparam logic [3:0] AluShr = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl = 4'hE;

  // FXNN functions
  localparam logic [7:0] FxGetDelay = 8'h07;
  localparam logic [7:0] FxWaitKey = 8'h0A;
  localparam logic [7:0] FxSetDelay = 8'h15;
  localparam logic [7:0] FxSetSound = 8'h17;
  localparam logic [7:0] FxSetSound2 = 8'h18;
  localparam logic [7:0] FxAddIdx = 8'h1E;
  localparam logic [7:0] FxFont = 8'h29;
  localparam logic [7:0] FxBcd = 8'h33;
  localparam logic [7:0] FxStore = 8'h55;
  localparam logic [7:0] FxLoad = 8'h65;

  typedef enum logic [4:0] {
    StClear,
    StIdle,
    StRead,
    StFetch1,
    StFetch2,
    StRegX,
    StRegY,
    StReg0,
    StExec,
    StCls,
    StRet0,
    StRet1,
    StRet2,
    StCall0,
    StCall1,
    StFlag,
    StDrawRow,
    StDrawSpr,
    StDrawLeft,
    StDrawRight,
    StDrawEnd,
    StBcd0,
    StBcd1,
    StBcd2,
    StStoreRd,
    StStoreWr,
    StLoadRd,
    StLoadWr,
    StFinish
  } state_e;

  // Split a byte into hundreds, tens and ones digits.
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [3:0] h;
    logic [3:0] t;
    logic [7:0] r;
    logic [7:0] o;
    h = 4'd0;
    r = v;
    if (v >= 8'd200) begin
      h = 4'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 4'd1;
      r = v - 8'd100;
    end
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(10 * k)) begin
        t = 4'(k);
      end
    end
    o = r - 8'(t) * 8'd10;
    return {h, t, o[3:0]};
  endfunction

endpackage

// ----- hw/rtl/c8ie_in_if.sv -----
// Input item channel: valid/ready handshake with the request fields.
interface c8ie_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [11:0] address;
  logic [7:0] data;
  logic [7:0] key_byte;

  modport source (output valid, output mode, output address, output data,
                  output key_byte, input ready);
  modport sink (input valid, input mode, input address, input data,
                input key_byte, output ready);
endinterface

// ----- hw/rtl/c8ie_out_if.sv -----
// Result item channel: valid/ready handshake with the result fields.
interface c8ie_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [11:0] program_counter;
  logic        halted;
  logic [1:0]  error_code;

  modport source (output valid, output read_data, output program_counter,
                  output halted, output error_code, input ready);
  modport sink (input valid, input read_data, input program_counter,
                input halted, input error_code, output ready);
endinterface

// ----- hw/rtl/c8ie_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module c8ie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/chip8_instruction_execute.sv -----
// CHIP-8 instruction execute core: sequencer around main memory and register file RAMs.
//
// One item loads a memory byte, reads one, or executes the instruction at the
// program counter; each item yields one result item with the read byte, the
// program counter, the halted flag and the error code. Main memory (4096
// bytes, display at 0x100, stack at the bottom, fonts at 0x800) and V0..VF
// are synchronous RAMs with one read and one write port each, so every
// memory read is registered. Ordinary instructions run two opcode fetches
// and three register reads, then execute. The memory port sets the long
// ones: clear screen zeroes the 256 display bytes, a sprite draw reads each
// drawn row's sprite byte and updates its left and right display bytes (only
// the left when the sprite starts in the rightmost byte column), BCD writes
// three digits, FX55/FX65 move one register at a time. After reset a clearing
// pass zeroes all 4096 memory bytes and the registers, one byte a cycle; no
// item is taken during the pass, though start_address writes are. Writing
// start_address reloads the program counter; the user must write it only
// while the core is idle, and the core itself does not enforce this. A new
// item is taken while the previous result still waits in the output register.
module chip8_instruction_execute
  import c8ie_pkg::*;
#(
  parameter int unsigned STACK_LIMIT = 62
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  c8ie_in_if.sink     in_i,
  c8ie_out_if.source  out_o
);

  localparam logic [5:0] StackLim = 6'(STACK_LIMIT);
  localparam logic [11:0] ResetPc = 12'h200;

  state_e state_q, state_d;

  logic [11:0] cnt_q, cnt_d;
  logic [11:0] pc_q, pc_d;
  logic [11:0] idx_q, idx_d;
  logic [5:0]  sp_q, sp_d;
  logic        stop_q, stop_d;
  logic [1:0]  fault_q, fault_d;
  logic [15:0] op_q, op_d;
  logic [7:0]  vx_q, vx_d;
  logic [7:0]  vy_q, vy_d;
  logic [7:0]  v0_q, v0_d;
  logic [7:0]  key_q, key_d;
  logic [7:0]  rd_q, rd_d;
  logic [3:0]  rethi_q, rethi_d;
  logic        flag_q, flag_d;
  logic        hit_q, hit_d;
  logic [15:0] win_q, win_d;

  logic        ov_q, ov_d;
  logic [7:0]  ord_q, ord_d;
  logic [11:0] opc_q, opc_d;
  logic        ohalt_q, ohalt_d;
  logic [1:0]  oerr_q, oerr_d;

  // memory ports
  logic             m_we;
  logic [MemAw-1:0] m_waddr, m_raddr;
  logic [7:0]       m_wdata, m_rdata;
  logic              v_we;
  logic [VRegAw-1:0] v_waddr, v_raddr;
  logic [7:0]        v_wdata, v_rdata;

  c8ie_ram #(.Width(8), .Depth(4096)) u_main_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  c8ie_ram #(.Width(8), .Depth(16)) u_vreg_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_waddr),
    .wdata_i(v_wdata),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

  // opcode fields
  logic [3:0]  op_grp, op_x, op_y, op_n;
  logic [7:0]  op_nn;
  logic [11:0] op_nnn;
  assign op_grp = op_q[15:12];
  assign op_x   = op_q[11:8];
  assign op_y   = op_q[7:4];
  assign op_n   = op_q[3:0];
  assign op_nn  = op_q[7:0];
  assign op_nnn = op_q[11:0];

  logic in_fire, out_fire, fin_go;
  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = ov_q && out_o.ready;
  assign fin_go     = !ov_q || out_o.ready;

  logic [11:0] pc_inc;
  assign pc_inc = pc_q + 12'd2;

  // ALU for the 8XYN group
  logic [7:0] alu_res;
  logic       alu_f;
  logic       alu_flag;
  logic [8:0] alu_sum;
  assign alu_sum = {1'b0, vx_q} + {1'b0, vy_q};
  always_comb begin
    alu_res  = vy_q;
    alu_f    = 1'b0;
    alu_flag = 1'b0;
    case (op_n)
      AluMov: alu_res = vy_q;
      AluOr:  alu_res = vx_q | vy_q;
      AluAnd: alu_res = vx_q & vy_q;
      AluXor: alu_res = vx_q ^ vy_q;
      AluAdd: begin
        alu_res  = alu_sum[7:0];
        alu_f    = alu_sum[8];
        alu_flag = 1'b1;
      end
      AluSub: begin
        alu_res  = vx_q - vy_q;
        alu_f    = (vx_q >= vy_q);
        alu_flag = 1'b1;
      end
      AluShr: begin
        alu_res  = {1'b0, vy_q[7:1]};
        alu_f    = vy_q[0];
        alu_flag = 1'b1;
      end
      AluSubn: begin
        alu_res  = vy_q - vx_q;
        alu_f    = (vy_q >= vx_q);
        alu_flag = 1'b1;
      end
      AluShl: begin
        alu_res  = {vy_q[6:0], 1'b0};
        alu_f    = vy_q[7];
        alu_flag = 1'b1;
      end
      default: begin
        alu_res  = vy_q;
        alu_f    = 1'b0;
        alu_flag = 1'b0;
      end
    endcase
  end

  logic alu_bad;
  assign alu_bad = (op_n > AluSubn) && (op_n != AluShl);

  // sprite row geometry: rows past the bottom edge and bytes past the right edge clip
  logic [3:0]  row;
  logic [5:0]  py;
  logic        row_ok;
  logic        col_last;
  logic [11:0] left_addr, right_addr;
  logic [2:0]  col_r;
  assign row        = cnt_q[3:0];
  assign py         = {1'b0, vy_q[4:0]} + {2'b00, row};
  assign row_ok     = (row != op_n) && !py[5];
  assign col_last   = (vx_q[5:3] == 3'd7);
  assign col_r      = vx_q[5:3] + 3'd1;
  assign left_addr  = DispBase + {4'b0000, py[4:0], vx_q[5:3]};
  assign right_addr = DispBase + {4'b0000, py[4:0], col_r};

  logic [11:0] bcd;
  assign bcd = bcd_digits(vx_q);

  logic mv_last;
  assign mv_last = (cnt_q[3:0] == op_x);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (cnt_q == 12'hFFF) state_d = StIdle;
      StIdle: begin
        if (in_fire) begin
          case (in_i.mode)
            ModeLoad: state_d = StFinish;
            ModeExec: state_d = stop_q ? StFinish : StFetch1;
            ModeRead: state_d = StRead;
            default:  state_d = StFinish;
          endcase
        end
      end
      StRead:   state_d = StFinish;
      StFetch1: state_d = StFetch2;
      StFetch2: state_d = StRegX;
      StRegX:   state_d = StRegY;
      StRegY:   state_d = StReg0;
      StReg0:   state_d = StExec;
      StExec: begin
        state_d = StFinish;
        if (op_q != OpHalt) begin
          case (op_grp)
            GrpSys: begin
              if (op_q == OpCls) state_d = StCls;
              else if (op_q == OpRet && sp_q != 6'd0) state_d = StRet0;
            end
            GrpCall: if (sp_q < StackLim) state_d = StCall0;
            GrpAlu:  if (alu_flag) state_d = StFlag;
            GrpDraw: state_d = StDrawRow;
            GrpMisc: begin
              case (op_nn)
                FxBcd:   state_d = StBcd0;
                FxStore: state_d = StStoreRd;
                FxLoad:  state_d = StLoadRd;
                default: state_d = StFinish;
              endcase
            end
            default: state_d = StFinish;
          endcase
        end
      end
      StCls:       if (cnt_q[7:0] == 8'hFF) state_d = StFinish;
      StRet0:      state_d = StRet1;
      StRet1:      state_d = StRet2;
      StRet2:      state_d = StFinish;
      StCall0:     state_d = StCall1;
      StCall1:     state_d = StFinish;
      StFlag:      state_d = StFinish;
      StDrawRow:   state_d = row_ok ? StDrawSpr : StDrawEnd;
      StDrawSpr:   state_d = StDrawLeft;
      StDrawLeft:  state_d = col_last ? StDrawRow : StDrawRight;
      StDrawRight: state_d = StDrawRow;
      StDrawEnd:   state_d = StFinish;
      StBcd0:      state_d = StBcd1;
      StBcd1:      state_d = StBcd2;
      StBcd2:      state_d = StFinish;
      StStoreRd:   state_d = StStoreWr;
      StStoreWr:   state_d = mv_last ? StFinish : StStoreRd;
      StLoadRd:    state_d = StLoadWr;
      StLoadWr:    state_d = mv_last ? StFinish : StLoadRd;
      StFinish:    if (fin_go) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d   = cnt_q;
    pc_d    = pc_q;
    idx_d   = idx_q;
    sp_d    = sp_q;
    stop_d  = stop_q;
    fault_d = fault_q;
    op_d    = op_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    v0_d    = v0_q;
    key_d   = key_q;
    rd_d    = rd_q;
    rethi_d = rethi_q;
    flag_d  = flag_q;
    hit_d   = hit_q;
    win_d   = win_q;
    ov_d    = out_fire ? 1'b0 : ov_q;
    ord_d   = ord_q;
    opc_d   = opc_q;
    ohalt_d = ohalt_q;
    oerr_d  = oerr_q;

    m_we    = 1'b0;
    m_waddr = cnt_q;
    m_wdata = 8'h00;
    m_raddr = pc_q;
    v_we    = 1'b0;
    v_waddr = op_x;
    v_wdata = 8'h00;
    v_raddr = op_x;

    case (state_q)
      StClear: begin
        // zero one memory byte a cycle; registers ride along on the first 16
        m_we    = 1'b1;
        m_waddr = cnt_q;
        v_we    = (cnt_q[11:4] == 8'h00);
        v_waddr = cnt_q[3:0];
        cnt_d   = cnt_q + 12'd1;
      end
      StIdle: begin
        m_raddr = (in_i.mode == ModeRead) ? in_i.address : pc_q;
        if (in_fire) begin
          key_d = in_i.key_byte;
          rd_d  = 8'h00;
          if (in_i.mode == ModeLoad) begin
            m_we    = 1'b1;
            m_waddr = in_i.address;
            m_wdata = in_i.data;
          end
        end
      end
      StRead: rd_d = m_rdata;
      StFetch1: begin
        op_d[15:8] = m_rdata;
        m_raddr    = pc_q + 12'd1;
      end
      StFetch2: begin
        op_d[7:0] = m_rdata;
        v_raddr   = op_x;
      end
      StRegX: begin
        vx_d    = v_rdata;
        v_raddr = op_y;
      end
      StRegY: begin
        vy_d    = v_rdata;
        v_raddr = 4'h0;
      end
      StReg0: v0_d = v_rdata;
      StExec: begin
        cnt_d = 12'd0;
        hit_d = 1'b0;
        pc_d  = pc_inc;
        if (op_q == OpHalt) begin
          stop_d = 1'b1;
          pc_d   = pc_q;
        end else begin
          case (op_grp)
            GrpSys: begin
              if (op_q == OpCls) begin
                pc_d = pc_q;
              end else if (op_q == OpRet) begin
                pc_d = pc_q;
                if (sp_q == 6'd0) begin
                  stop_d  = 1'b1;
                  fault_d = ErrRetEmpty;
                end else begin
                  sp_d = sp_q - 6'd2;
                end
              end else if (op_q != OpNop) begin
                pc_d    = pc_q;
                stop_d  = 1'b1;
                fault_d = ErrBadOp;
              end
            end
            GrpJump: pc_d = op_nnn;
            GrpCall: begin
              pc_d = pc_q;
              if (sp_q >= StackLim) begin
                stop_d  = 1'b1;
                fault_d = ErrCallFull;
              end
            end
            GrpSkipEqI: if (vx_q == op_nn) pc_d = pc_q + 12'd4;
            GrpSkipNeI: if (vx_q != op_nn) pc_d = pc_q + 12'd4;
            GrpSkipEqR, GrpSkipNeR: begin
              if (op_n != 4'h0) begin
                pc_d    = pc_q;
                stop_d  = 1'b1;
                fault_d = ErrBadOp;
              end else if ((vx_q == vy_q) == (op_grp == GrpSkipEqR)) begin
                pc_d = pc_q + 12'd4;
              end
            end
            GrpLoadI: begin
              v_we    = 1'b1;
              v_wdata = op_nn;
            end
            GrpAddI: begin
              v_we    = 1'b1;
              v_wdata = vx_q + op_nn;
            end
            GrpAlu: begin
              if (alu_bad) begin
                pc_d    = pc_q;
                stop_d  = 1'b1;
                fault_d = ErrBadOp;
              end else begin
                // VF lands in the next cycle, after Vx
                v_we    = 1'b1;
                v_wdata = alu_res;
                flag_d  = alu_f;
                if (alu_flag) pc_d = pc_q;
              end
            end
            GrpSetIdx: idx_d = op_nnn;
            GrpJumpV0: pc_d = {4'h0, v0_q} + op_nnn;
            GrpRand, GrpKey: pc_d = pc_inc;
            GrpDraw: pc_d = pc_q;
            GrpMisc: begin
              case (op_nn)
                FxGetDelay, FxSetDelay, FxSetSound, FxSetSound2: pc_d = pc_inc;
                FxWaitKey: begin
                  v_we    = 1'b1;
                  v_wdata = key_q;
                end
                FxAddIdx: idx_d = idx_q + {4'h0, vx_q};
                FxFont:   idx_d = FontBase + {4'h0, vx_q[3:0], 4'h0};
                FxBcd, FxStore, FxLoad: pc_d = pc_q;
                default: begin
                  pc_d    = pc_q;
                  stop_d  = 1'b1;
                  fault_d = ErrBadOp;
                end
              endcase
            end
            default: pc_d = pc_inc;
          endcase
        end
      end
      StCls: begin
        m_we    = 1'b1;
        m_waddr = DispBase + {4'h0, cnt_q[7:0]};
        cnt_d   = cnt_q + 12'd1;
        if (cnt_q[7:0] == 8'hFF) begin
          pc_d  = pc_inc;
          cnt_d = 12'd0;
        end
      end
      StRet0: m_raddr = {6'd0, sp_q};
      StRet1: begin
        rethi_d = m_rdata[3:0];
        m_raddr = {6'd0, sp_q} + 12'd1;
      end
      StRet2: pc_d = {rethi_q, m_rdata} + 12'd2;
      StCall0: begin
        m_we    = 1'b1;
        m_waddr = {6'd0, sp_q};
        m_wdata = {4'h0, pc_q[11:8]};
      end
      StCall1: begin
        m_we    = 1'b1;
        m_waddr = {6'd0, sp_q} + 12'd1;
        m_wdata = pc_q[7:0];
        sp_d    = sp_q + 6'd2;
        pc_d    = op_nnn;
      end
      StFlag: begin
        v_we    = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'd0, flag_q};
        pc_d    = pc_inc;
      end
      StDrawRow: m_raddr = idx_q + {8'h00, row};
      StDrawSpr: begin
        win_d   = {m_rdata, 8'h00} >> vx_q[2:0];
        m_raddr = left_addr;
      end
      StDrawLeft: begin
        m_we    = 1'b1;
        m_waddr = left_addr;
        m_wdata = m_rdata ^ win_q[15:8];
        hit_d   = hit_q | (|(m_rdata & win_q[15:8]));
        m_raddr = right_addr;
        if (col_last) cnt_d = cnt_q + 12'd1;
      end
      StDrawRight: begin
        m_we    = 1'b1;
        m_waddr = right_addr;
        m_wdata = m_rdata ^ win_q[7:0];
        hit_d   = hit_q | (|(m_rdata & win_q[7:0]));
        cnt_d   = cnt_q + 12'd1;
      end
      StDrawEnd: begin
        v_we    = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'd0, hit_q};
        pc_d    = pc_inc;
      end
      StBcd0: begin
        m_we    = 1'b1;
        m_waddr = idx_q;
        m_wdata = {4'h0, bcd[11:8]};
      end
      StBcd1: begin
        m_we    = 1'b1;
        m_waddr = idx_q + 12'd1;
        m_wdata = {4'h0, bcd[7:4]};
      end
      StBcd2: begin
        m_we    = 1'b1;
        m_waddr = idx_q + 12'd2;
        m_wdata = {4'h0, bcd[3:0]};
        pc_d    = pc_inc;
      end
      StStoreRd: v_raddr = cnt_q[3:0];
      StStoreWr: begin
        m_we    = 1'b1;
        m_waddr = idx_q + {8'h00, cnt_q[3:0]};
        m_wdata = v_rdata;
        cnt_d   = cnt_q + 12'd1;
        if (mv_last) pc_d = pc_inc;
      end
      StLoadRd: m_raddr = idx_q + {8'h00, cnt_q[3:0]};
      StLoadWr: begin
        v_we    = 1'b1;
        v_waddr = cnt_q[3:0];
        v_wdata = m_rdata;
        cnt_d   = cnt_q + 12'd1;
        if (mv_last) pc_d = pc_inc;
      end
      StFinish: begin
        if (fin_go) begin
          ov_d    = 1'b1;
          ord_d   = rd_q;
          opc_d   = pc_q;
          ohalt_d = stop_q;
          oerr_d  = fault_q;
        end
      end
      default: cnt_d = cnt_q;
    endcase

    // start_address write reloads the program counter
    if (cfg_we_i) pc_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= 12'd0;
      pc_q    <= ResetPc;
      idx_q   <= 12'd0;
      sp_q    <= 6'd0;
      stop_q  <= 1'b0;
      fault_q <= ErrNone;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      idx_q   <= idx_d;
      sp_q    <= sp_d;
      stop_q  <= stop_d;
      fault_q <= fault_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    v0_q    <= v0_d;
    key_q   <= key_d;
    rd_q    <= rd_d;
    rethi_q <= rethi_d;
    flag_q  <= flag_d;
    hit_q   <= hit_d;
    win_q   <= win_d;
    ord_q   <= ord_d;
    opc_q   <= opc_d;
    ohalt_q <= ohalt_d;
    oerr_q  <= oerr_d;
  end

  assign out_o.valid           = ov_q;
  assign out_o.read_data       = ord_q;
  assign out_o.program_counter = opc_q;
  assign out_o.halted          = ohalt_q;
  assign out_o.error_code      = oerr_q;

endmodule

// ----- bench/chip8_instruction_execute_test.sv -----
// Self-checking testbench for the CHIP-8 instruction execute core, with a tracking predictor.
`timescale 1ns / 1ps

module chip8_instruction_execute_test;
  import c8ie_pkg::*;

  localparam int unsigned StackCap = 62;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainWait = 400;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  key;
  } req_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic [11:0] pc;
    logic        halted;
    logic [1:0]  err;
  } res_t;

  // One row of the directed table: either a plain item, or an opcode that is
  // first loaded at the program counter and then executed.
  typedef struct packed {
    bit          is_op;
    logic [15:0] op;
    req_t        req;
    bit          chk;
    res_t        want;
  } drow_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [11:0] cfg_wdata_i;

  c8ie_in_if  in_i ();
  c8ie_out_if out_o ();

  chip8_instruction_execute dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o)
  );

  // Shadow state of the core.
  logic [7:0]  shadow_mem [4096];
  logic [7:0]  shadow_v [16];
  logic [11:0] core_pc;
  logic [11:0] core_idx;
  logic [5:0]  core_sp;
  logic        core_stop;
  logic [1:0]  core_fault;
  logic [11:0] start_pc;

  res_t result_q [$];
  int   fail_cnt;
  int   items_taken;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_go;
  bit   hold_done;
  int   hold_cnt;
  int   quiet_cycles;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Sprite draw: XOR onto the display, clip at the right and bottom edges.
  task automatic draw_sprite(input logic [7:0] vx, input logic [7:0] vy, input logic [3:0] rows);
    int x0;
    int y0;
    int py;
    int px;
    logic [7:0] bits;
    logic [11:0] a;
    logic [7:0] m;
    logic hit;
    x0 = vx & 63;
    y0 = vy & 31;
    hit = 1'b0;
    for (int r = 0; r < rows; r++) begin
      py = y0 + r;
      if (py >= 32) break;
      bits = shadow_mem[12'(core_idx + r)];
      for (int c = 0; c < 8; c++) begin
        px = x0 + c;
        if (px >= 64) break;
        if (bits[7 - c]) begin
          a = DispBase + 12'(py * 8 + (px >> 3));
          m = 8'h80 >> (px & 7);
          if ((shadow_mem[a] & m) != 0) hit = 1'b1;
          shadow_mem[a] = shadow_mem[a] ^ m;
        end
      end
    end
    shadow_v[15] = {7'd0, hit};
  endtask

  task automatic raise_fault(input logic [1:0] code);
    core_fault = code;
    core_stop = 1'b1;
  endtask

  // Execute the instruction at the shadow program counter.
  task automatic run_instr(input logic [7:0] key);
    logic [15:0] op;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] n;
    logic [7:0] nn;
    logic [11:0] nnn;
    logic [7:0] vx;
    logic [7:0] vy;
    logic [8:0] wide;
    logic [7:0] res;
    logic flag;
    logic f;
    op = {shadow_mem[core_pc], shadow_mem[12'(core_pc + 1)]};
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    nnn = op[11:0];
    vx = shadow_v[x];
    vy = shadow_v[y];
    if (op == OpHalt) begin
      core_stop = 1'b1;
      return;
    end
    case (op[15:12])
      GrpSys: begin
        if (op == OpCls) begin
          for (int i = 0; i < 256; i++) shadow_mem[DispBase + 12'(i)] = 8'h00;
        end else if (op == OpRet) begin
          if (core_sp == 0) begin
            raise_fault(ErrRetEmpty);
            return;
          end
          core_sp = core_sp - 6'd2;
          core_pc = {shadow_mem[core_sp][3:0], shadow_mem[12'(core_sp) + 12'd1]};
        end else if (op != OpNop) begin
          raise_fault(ErrBadOp);
          return;
        end
      end
      GrpJump: begin
        core_pc = nnn;
        return;
      end
      GrpCall: begin
        if (core_sp >= StackCap) begin
          raise_fault(ErrCallFull);
          return;
        end
        shadow_mem[12'(core_sp)] = {4'd0, core_pc[11:8]};
        shadow_mem[12'(core_sp) + 12'd1] = core_pc[7:0];
        core_sp = core_sp + 6'd2;
        core_pc = nnn;
        return;
      end
      GrpSkipEqI: if (vx == nn) core_pc = core_pc + 12'd2;
      GrpSkipNeI: if (vx != nn) core_pc = core_pc + 12'd2;
      GrpSkipEqR, GrpSkipNeR: begin
        if (n != 0) begin
          raise_fault(ErrBadOp);
          return;
        end
        if ((vx == vy) == (op[15:12] == GrpSkipEqR)) core_pc = core_pc + 12'd2;
      end
      GrpLoadI: shadow_v[x] = nn;
      GrpAddI: shadow_v[x] = vx + nn;
      GrpAlu: begin
        flag = 1'b1;
        f = 1'b0;
        case (n)
          AluMov: begin res = vy; flag = 1'b0; end
          AluOr: begin res = vx | vy; flag = 1'b0; end
          AluAnd: begin res = vx & vy; flag = 1'b0; end
          AluXor: begin res = vx ^ vy; flag = 1'b0; end
          AluAdd: begin
            wide = {1'b0, vx} + {1'b0, vy};
            res = wide[7:0];
            f = wide[8];
          end
          AluSub: begin res = vx - vy; f = (vx >= vy); end
          AluShr: begin res = vy >> 1; f = vy[0]; end
          AluSubn: begin res = vy - vx; f = (vy >= vx); end
          AluShl: begin res = vy << 1; f = vy[7]; end
          default: begin
            raise_fault(ErrBadOp);
            return;
          end
        endcase
        shadow_v[x] = res;
        if (flag) shadow_v[15] = {7'd0, f};
      end
      GrpSetIdx: core_idx = nnn;
      GrpJumpV0: begin
        core_pc = 12'(shadow_v[0]) + nnn;
        return;
      end
      GrpRand, GrpKey: ;
      GrpDraw: draw_sprite(vx, vy, n);
      default: begin
        case (nn)
          FxGetDelay, FxSetDelay, FxSetSound, FxSetSound2: ;
          FxWaitKey: shadow_v[x] = key;
          FxAddIdx: core_idx = core_idx + 12'(vx);
          FxFont: core_idx = FontBase + {4'd0, vx[3:0], 4'd0};
          FxBcd: begin
            shadow_mem[core_idx] = 8'(vx / 100);
            shadow_mem[12'(core_idx + 1)] = 8'((vx / 10) % 10);
            shadow_mem[12'(core_idx + 2)] = 8'(vx % 10);
          end
          FxStore: for (int i = 0; i <= x; i++) shadow_mem[12'(core_idx + i)] = shadow_v[i];
          FxLoad: for (int i = 0; i <= x; i++) shadow_v[i] = shadow_mem[12'(core_idx + i)];
          default: begin
            raise_fault(ErrBadOp);
            return;
          end
        endcase
      end
    endcase
    core_pc = core_pc + 12'd2;
  endtask

  task automatic model_item(input req_t rq, output res_t rs);
    rs.rd = 8'h00;
    case (rq.mode)
      ModeLoad: shadow_mem[rq.addr] = rq.data;
      ModeExec: if (!core_stop) run_instr(rq.key);
      ModeRead: rs.rd = shadow_mem[rq.addr];
      default: ;
    endcase
    rs.pc = core_pc;
    rs.halted = core_stop;
    rs.err = core_fault;
  endtask

  // Offer one item, hold it until taken, then record what the core must return.
  task automatic send_item(input req_t rq, input bit chk, input res_t want);
    res_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.mode <= rq.mode;
    in_i.address <= rq.addr;
    in_i.data <= rq.data;
    in_i.key_byte <= rq.key;
    @(posedge clk_i);
    while (!in_i.ready) @(posedge clk_i);
    model_item(rq, got);
    result_q.push_back(chk ? want : got);
    items_taken++;
  endtask

  task automatic send_plain(input logic [1:0] mode, input logic [11:0] addr,
                            input logic [7:0] data, input logic [7:0] key);
    send_item('{mode, addr, data, key}, 1'b0, '0);
  endtask

  // Place an opcode at the program counter and execute it.
  task automatic run_opcode(input logic [15:0] op, input bit chk, input res_t want);
    logic [11:0] at;
    at = core_pc;
    send_plain(ModeLoad, at, op[15:8], 8'($urandom));
    send_plain(ModeLoad, at + 12'd1, op[7:0], 8'($urandom));
    send_item('{ModeExec, 12'($urandom), 8'($urandom), 8'($urandom)}, chk, want);
  endtask

  // Opcode that keeps the core running.
  function automatic logic [15:0] pick_opcode();
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] nn;
    logic [15:0] op;
    int unsigned sel;
    logic [7:0] fx_ops [10];
    logic [3:0] alu_ops [9];
    fx_ops = '{FxGetDelay, FxWaitKey, FxSetDelay, FxSetSound, FxSetSound2,
               FxAddIdx, FxFont, FxBcd, FxStore, FxLoad};
    alu_ops = '{AluMov, AluOr, AluAnd, AluXor, AluAdd, AluSub, AluShr, AluSubn, AluShl};
    x = 4'($urandom);
    y = 4'($urandom);
    nn = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 2) op = OpCls;
    else if (sel < 6) op = (core_sp != 0) ? OpRet : OpNop;
    else if (sel < 9) op = {GrpJump, 12'($urandom)};
    else if (sel < 14) op = (core_sp < StackCap) ? {GrpCall, 12'($urandom)} : OpNop;
    else if (sel < 20) op = {GrpSkipEqI, x, (sel[0] ? shadow_v[x] : nn)};
    else if (sel < 25) op = {GrpSkipNeI, x, (sel[0] ? shadow_v[x] : nn)};
    else if (sel < 29) op = {GrpSkipEqR, x, y, 4'd0};
    else if (sel < 33) op = {GrpSkipNeR, x, y, 4'd0};
    else if (sel < 43) op = {GrpLoadI, x, nn};
    else if (sel < 49) op = {GrpAddI, x, nn};
    else if (sel < 67) op = {GrpAlu, x, y, alu_ops[$urandom_range(8)]};
    else if (sel < 72) op = {GrpSetIdx, 12'($urandom)};
    else if (sel < 74) op = {GrpJumpV0, 12'($urandom)};
    else if (sel < 76) op = {GrpRand, x, nn};
    else if (sel < 78) op = {GrpKey, x, nn};
    else if (sel < 85) op = {GrpDraw, x, y, 4'($urandom)};
    else op = {GrpMisc, x, fx_ops[$urandom_range(9)]};
    return op;
  endfunction

  task automatic settle();
    in_i.valid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [11:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_pc = v;
    core_pc = v;
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = items_taken + count;
    while (items_taken < stop_at) begin
      if ($urandom_range(99) < 12) begin
        // noise: loads, reads and spare-mode items at any address
        case ($urandom_range(2))
          0: send_plain(ModeLoad, 12'($urandom), 8'($urandom), 8'($urandom));
          1: send_plain(ModeRead, 12'($urandom), 8'($urandom), 8'($urandom));
          default: send_plain(ModeSpare, 12'($urandom), 8'($urandom), 8'($urandom));
        endcase
      end else begin
        run_opcode(pick_opcode(), 1'b0, '0);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      out_o.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HoldCycles) hold_done <= 1'b1;
    end else begin
      out_o.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result item: pc %h", out_o.program_counter);
        fail_cnt++;
      end else begin
        exp_r = result_q.pop_front();
        if (out_o.read_data !== exp_r.rd) begin
          $error("read_data expected %h actual %h", exp_r.rd, out_o.read_data);
          fail_cnt++;
        end
        if (out_o.program_counter !== exp_r.pc) begin
          $error("program_counter expected %h actual %h", exp_r.pc, out_o.program_counter);
          fail_cnt++;
        end
        if (out_o.halted !== exp_r.halted) begin
          $error("halted expected %b actual %b", exp_r.halted, out_o.halted);
          fail_cnt++;
        end
        if (out_o.error_code !== exp_r.err) begin
          $error("error_code expected %0d actual %0d", exp_r.err, out_o.error_code);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any handshake.
  always @(posedge clk_i) begin
    if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    drow_t dir_tab [12];
    int kind;
    // Directed rows: reads after reset, field extremes, the spare mode, then
    // clipped draw at the bottom-right corner, arithmetic flags, BCD with a
    // wrapping index, and a screen clear.
    dir_tab[0] = '{1'b0, 16'h0, '{ModeRead, 12'h000, 8'h00, 8'h00}, 1'b1,
                   '{8'h00, 12'h200, 1'b0, ErrNone}};
    dir_tab[1] = '{1'b0, 16'h0, '{ModeLoad, 12'hFFF, 8'hFF, 8'hFF}, 1'b1,
                   '{8'h00, 12'h200, 1'b0, ErrNone}};
    dir_tab[2] = '{1'b0, 16'h0, '{ModeRead, 12'hFFF, 8'h00, 8'h00}, 1'b1,
                   '{8'hFF, 12'h200, 1'b0, ErrNone}};
    dir_tab[3] = '{1'b0, 16'h0, '{ModeSpare, 12'hFFF, 8'hFF, 8'hFF}, 1'b1,
                   '{8'h00, 12'h200, 1'b0, ErrNone}};
    dir_tab[4] = '{1'b1, OpNop, '0, 1'b1, '{8'h00, 12'h202, 1'b0, ErrNone}};
    dir_tab[5] = '{1'b1, 16'h6AFF, '0, 1'b0, '0};
    dir_tab[6] = '{1'b1, 16'h6B3F, '0, 1'b0, '0};
    dir_tab[7] = '{1'b1, 16'hAFFE, '0, 1'b0, '0};
    dir_tab[8] = '{1'b1, 16'hDABF, '0, 1'b0, '0};
    dir_tab[9] = '{1'b1, 16'h8AB4, '0, 1'b0, '0};
    dir_tab[10] = '{1'b1, 16'hFA33, '0, 1'b0, '0};
    dir_tab[11] = '{1'b1, OpCls, '0, 1'b0, '0};

    for (int i = 0; i < 4096; i++) shadow_mem[i] = 8'h00;
    for (int i = 0; i < 16; i++) shadow_v[i] = 8'h00;
    start_pc = 12'h200;
    core_pc = start_pc;
    core_idx = '0;
    core_sp = '0;
    core_stop = 1'b0;
    core_fault = ErrNone;
    fail_cnt = 0;
    items_taken = 0;
    quiet_cycles = 0;
    hold_go = 1'b0;
    tx_idle_pct = 28;
    rx_idle_pct = 46;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_i.valid = 1'b0;
    in_i.mode = ModeLoad;
    in_i.address = '0;
    in_i.data = '0;
    in_i.key_byte = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_op) run_opcode(dir_tab[i].op, dir_tab[i].chk, dir_tab[i].want);
      else send_item(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].want);
    end
    // key wait with the widest key value
    send_plain(ModeLoad, core_pc, 8'hF5, 8'h00);
    send_plain(ModeLoad, core_pc + 12'd1, FxWaitKey, 8'h00);
    send_plain(ModeExec, 12'h000, 8'h00, 8'hFF);

    random_phase(220);

    // swap the idle rates; restart at the top of memory so fetches wrap
    settle();
    tx_idle_pct = 46;
    rx_idle_pct = 28;
    write_start(12'hFFF);
    random_phase(220);

    // no idling; then hold the receiver off so the core backs up
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_start(12'h000);
    random_phase(40);
    settle();
    write_start(12'($urandom_range(12'h300, 12'hEFF)));
    hold_go = 1'b1;
    random_phase(230);

    // One terminal event per run: halt, or one of the three faults.
    kind = $urandom_range(3);
    case (kind)
      0: run_opcode(OpHalt, 1'b0, '0);
      1: begin
        while (core_sp != 0) run_opcode(OpRet, 1'b0, '0);
        run_opcode(OpRet, 1'b0, '0);
      end
      2: begin
        while (core_sp < StackCap) run_opcode({GrpCall, 12'($urandom)}, 1'b0, '0);
        run_opcode({GrpCall, 12'($urandom)}, 1'b0, '0);
      end
      default: begin
        case ($urandom_range(3))
          0: run_opcode({GrpAlu, 8'($urandom), 4'hF}, 1'b0, '0);
          1: run_opcode({GrpSkipEqR, 8'($urandom), 4'($urandom_range(1, 15))}, 1'b0, '0);
          2: run_opcode({GrpMisc, 4'($urandom), 8'hFF}, 1'b0, '0);
          default: run_opcode(16'h0123, 1'b0, '0);
        endcase
      end
    endcase
    // the core is stopped now: executes change nothing, loads and reads still work
    run_opcode(pick_opcode(), 1'b0, '0);
    send_plain(ModeExec, 12'h000, 8'h00, 8'h00);
    send_plain(ModeRead, core_pc, 8'h00, 8'h00);

    settle();
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
